### hw/rtl/slbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package slbs_pkg;
	localparam int POS_WIDTH = 16;

	localparam logic [5:0] K_IDENT = 6'd0;
	localparam logic [5:0] K_INT   = 6'd1;
	localparam logic [5:0] K_PRIM  = 6'd2;
	localparam logic [5:0] K_FUNC  = 6'd3;
	localparam logic [5:0] K_ERROR = 6'd37;

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_WORD    = 3'd1;
	localparam logic [2:0] M_NUM     = 3'd2;
	localparam logic [2:0] M_SUFFIX  = 3'd3;
	localparam logic [2:0] M_OP      = 3'd4;
	localparam logic [2:0] M_COMMENT = 3'd5;
	localparam logic [2:0] M_ERROR   = 3'd6;

	localparam logic [3:0] SUF_NONE = 4'd8;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [5:0]           token_kind;
		logic [3:0]           prim_code;
		logic [3:0]           suffix_code;
		logic                 suffix_bad;
		logic [POS_WIDTH-1:0] start_row;
		logic [POS_WIDTH-1:0] start_col;
		logic [POS_WIDTH-1:0] token_length;
		logic                 run_last;
	} out_item_t;

	// primitive type names, little-endian bytes, with their lengths
	localparam logic [39:0] PRIM_NAME [14] = '{
		40'h0072616863, 40'h0064696f76, 40'h0000323366, 40'h0000343666,
		40'h657a697375, 40'h657a697369, 40'h0000343675, 40'h0000343669,
		40'h0000323375, 40'h0000323369, 40'h0000363175, 40'h0000363169,
		40'h0000003875, 40'h0000003869};
	localparam logic [2:0] PRIM_LEN [14] = '{
		3'd4, 3'd4, 3'd3, 3'd3, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd2, 3'd2};
	localparam logic [39:0] FUNC_NAME = 40'h00636e7546;

	// single-byte punctuation kind, 0 when not a single-byte token
	function automatic logic [5:0] punct_kind(input logic [7:0] b);
		case (b)
			8'h7b: punct_kind = 6'd4;
			8'h7d: punct_kind = 6'd5;
			8'h28: punct_kind = 6'd6;
			8'h29: punct_kind = 6'd7;
			8'h5b: punct_kind = 6'd8;
			8'h5d: punct_kind = 6'd9;
			8'h3a: punct_kind = 6'd10;
			8'h3b: punct_kind = 6'd11;
			8'h2c: punct_kind = 6'd12;
			8'h5e: punct_kind = 6'd24;
			8'h7e: punct_kind = 6'd25;
			8'h2b: punct_kind = 6'd28;
			8'h2a: punct_kind = 6'd30;
			8'h25: punct_kind = 6'd32;
			8'h40: punct_kind = 6'd34;
			8'h2e: punct_kind = 6'd35;
			default: punct_kind = 6'd0;
		endcase
	endfunction

	function automatic logic is_op_start(input logic [7:0] b);
		is_op_start = (b == 8'h3d) || (b == 8'h21) || (b == 8'h3c) || (b == 8'h3e) ||
			(b == 8'h7c) || (b == 8'h2d) || (b == 8'h2f) || (b == 8'h26);
	endfunction

	function automatic logic [5:0] op_single(input logic [7:0] c);
		case (c)
			8'h3d: op_single = 6'd13;
			8'h21: op_single = 6'd16;
			8'h3c: op_single = 6'd19;
			8'h3e: op_single = 6'd20;
			8'h7c: op_single = 6'd23;
			8'h2d: op_single = 6'd29;
			8'h2f: op_single = 6'd31;
			default: op_single = 6'd33;
		endcase
	endfunction

	// two-byte operator kind, 1 for comment opener, 0 for no pair
	function automatic logic [5:0] op_pair(input logic [7:0] a, input logic [7:0] b);
		op_pair = 6'd0;
		if (a == 8'h3d && b == 8'h3d) op_pair = 6'd17;
		if (a == 8'h21 && b == 8'h3d) op_pair = 6'd18;
		if (a == 8'h3c && b == 8'h3c) op_pair = 6'd26;
		if (a == 8'h3c && b == 8'h3d) op_pair = 6'd21;
		if (a == 8'h3e && b == 8'h3e) op_pair = 6'd27;
		if (a == 8'h3e && b == 8'h3d) op_pair = 6'd22;
		if (a == 8'h7c && b == 8'h7c) op_pair = 6'd14;
		if (a == 8'h2d && b == 8'h3e) op_pair = 6'd36;
		if (a == 8'h26 && b == 8'h26) op_pair = 6'd15;
		if (a == 8'h2f && b == 8'h2f) op_pair = 6'd1;
	endfunction
endpackage
`default_nettype wire

### hw/rtl/source_lexer_byte_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte-stream source lexer.
// Input channel in_valid/in_ready carries one text byte per request plus a
// final flag; output channel out_valid/out_ready carries one token per request
// on out_data. A byte produces zero, one or two tokens; run_last marks the last.
// The byte is lexed in the cycle it is accepted and its tokens land in a
// three-entry output queue; the first token is registered into the queue as
// the request is accepted, the second moves to the head when the first is taken.
// A byte is accepted whenever the queue will have room for two tokens after
// this cycle's take, so bytes go in back to back at one per cycle while the
// receiver takes every token; a byte that makes two tokens puts both in the
// queue, so a run of those is paced by the receiver.
// Reset clears the scanner to idle at row 0, column 0 and empties the queue.
// When the receiver stalls the queue holds its tokens and in_ready drops once
// the queue cannot take two more.
module source_lexer_byte_stream (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire slbs_pkg::in_item_t      in_data,
	output logic                         out_valid,
	input  wire                          out_ready,
	output slbs_pkg::out_item_t          out_data
);
	localparam int POS_WIDTH = slbs_pkg::POS_WIDTH;
	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
	localparam int TW = 6 + 4 + 4 + 1 + 3 * POS_WIDTH + 1;

	typedef struct packed {
		logic [5:0]           kind;
		logic [3:0]           prim;
		logic [3:0]           suf;
		logic                 bad;
		logic [POS_WIDTH-1:0] row;
		logic [POS_WIDTH-1:0] col;
		logic [POS_WIDTH-1:0] len;
		logic                 last;
	} tok_t;

	// scanner state
	logic [2:0]           mode_q;
	logic [7:0]           pend_q;
	logic [39:0]          prefix_q;
	logic [POS_WIDTH-1:0] runlen_q, trow_q, tcol_q, crow_q, ccol_q;
	logic                 sletter_q;
	logic [6:0]           sdig_q;

	logic [2:0]           mode_d;
	logic [7:0]           pend_d;
	logic [39:0]          prefix_d;
	logic [POS_WIDTH-1:0] runlen_d, trow_d, tcol_d, crow_d, ccol_d;
	logic                 sletter_d;
	logic [6:0]           sdig_d;

	tok_t                 e0, e1;
	logic                 v0, v1;

	// output queue
	logic [TW-1:0] q_q [3];
	logic [1:0]    cnt_q;
	logic          take;
	logic          acc;

	assign take = out_valid && out_ready;
	assign in_ready = (cnt_q < 2'd2) || (cnt_q == 2'd2 && take);
	assign acc = in_valid && in_ready;

	function automatic logic [POS_WIDTH-1:0] sinc(input logic [POS_WIDTH-1:0] x);
		sinc = (x == POS_MAX) ? x : x + 1'b1;
	endfunction

	// lexing of one byte
	always_comb begin
		logic [7:0] b;
		logic       last, alpha, digit, space, wordch, fl, st;
		logic [5:0] k, pk;
		logic [7:0] v;
		tok_t       t;
		b = in_data.text_byte;
		last = in_data.final_byte || (b == 8'h00);
		alpha = ((b | 8'h20) >= 8'h61) && ((b | 8'h20) <= 8'h7a);
		digit = (b >= 8'h30) && (b <= 8'h39);
		space = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
		wordch = alpha || digit || b == 8'h5f;
		mode_d = mode_q; pend_d = pend_q; prefix_d = prefix_q; runlen_d = runlen_q;
		trow_d = trow_q; tcol_d = tcol_q; crow_d = crow_q; ccol_d = ccol_q;
		sletter_d = sletter_q; sdig_d = sdig_q;
		e0 = '0; e1 = '0; v0 = 1'b0; v1 = 1'b0;
		fl = 1'b0; st = 1'b0;
		pk = 6'd0; v = 8'd0;
		k = slbs_pkg::op_pair(pend_q, b);
		// the flush token for the current mode
		t = '0;
		t.row = trow_q; t.col = tcol_q; t.len = runlen_q;
		case (mode_q)
			slbs_pkg::M_WORD: begin
				t.kind = slbs_pkg::K_IDENT;
				for (int i = 13; i >= 0; i--)
					if (prefix_q == slbs_pkg::PRIM_NAME[i] &&
						runlen_q == POS_WIDTH'(slbs_pkg::PRIM_LEN[i])) begin
						t.kind = slbs_pkg::K_PRIM; t.prim = 4'(i);
					end
				if (prefix_q == slbs_pkg::FUNC_NAME && runlen_q == POS_WIDTH'(4)) begin
					t.kind = slbs_pkg::K_FUNC; t.prim = 4'd0;
				end
			end
			slbs_pkg::M_NUM: begin
				t.kind = slbs_pkg::K_INT; t.suf = slbs_pkg::SUF_NONE;
			end
			slbs_pkg::M_SUFFIX: begin
				t.kind = slbs_pkg::K_INT;
				case (sdig_q)
					7'd8:  t.suf = {3'd0, sletter_q};
					7'd16: t.suf = {3'd1, sletter_q};
					7'd32: t.suf = {3'd2, sletter_q};
					7'd64: t.suf = {3'd3, sletter_q};
					default: t.bad = 1'b1;
				endcase
			end
			slbs_pkg::M_OP: begin
				t.kind = slbs_pkg::op_single(pend_q); t.len = POS_WIDTH'(1);
			end
			default: ;
		endcase
		if (b != 8'h00) begin
			case (mode_q)
				slbs_pkg::M_ERROR: ;
				slbs_pkg::M_WORD: begin
					if (wordch) begin
						if (runlen_q < POS_WIDTH'(5))
							prefix_d = prefix_q | (40'(b) << {runlen_q[2:0], 3'b000});
						runlen_d = sinc(runlen_q);
					end else begin fl = 1'b1; st = 1'b1; end
				end
				slbs_pkg::M_NUM: begin
					if (digit) runlen_d = sinc(runlen_q);
					else if (b == 8'h75 || b == 8'h69) begin
						mode_d = slbs_pkg::M_SUFFIX; sletter_d = (b == 8'h69);
						sdig_d = 7'd0; runlen_d = sinc(runlen_q);
					end else begin fl = 1'b1; st = 1'b1; end
				end
				slbs_pkg::M_SUFFIX: begin
					if (digit) begin
						if (sdig_q == 7'd0) v = (b == 8'h30) ? 8'd127 : b - 8'h30;
						else if (sdig_q < 7'd127) begin
							v = 8'(({1'b0, sdig_q, 3'b000} + {2'b0, sdig_q, 1'b0}) > 10'd127
								? 10'd127 : ({1'b0, sdig_q, 3'b000} + {2'b0, sdig_q, 1'b0}
								+ 10'(b - 8'h30)));
							if (v > 8'd127) v = 8'd127;
						end else v = 8'd127;
						sdig_d = v[6:0];
						runlen_d = sinc(runlen_q);
					end else begin fl = 1'b1; st = 1'b1; end
				end
				slbs_pkg::M_OP: begin
					if (k == 6'd1) mode_d = slbs_pkg::M_COMMENT;
					else if (k != 6'd0) begin
						v0 = 1'b1; e0 = t; e0.kind = k; e0.len = POS_WIDTH'(2);
						mode_d = slbs_pkg::M_IDLE;
					end else begin fl = 1'b1; st = 1'b1; end
				end
				slbs_pkg::M_COMMENT: begin
					if (b == 8'h0a) begin mode_d = slbs_pkg::M_IDLE; st = 1'b1; end
				end
				default: begin mode_d = slbs_pkg::M_IDLE; st = 1'b1; end
			endcase
			if (fl) begin
				v0 = 1'b1; e0 = t; mode_d = slbs_pkg::M_IDLE;
			end
			// start of a new token
			if (st) begin
				trow_d = crow_q; tcol_d = ccol_q;
				pk = slbs_pkg::punct_kind(b);
				if (space) ;
				else if (alpha || b == 8'h5f) begin
					mode_d = slbs_pkg::M_WORD; prefix_d = {32'd0, b};
					runlen_d = POS_WIDTH'(1);
				end else if (digit) begin
					mode_d = slbs_pkg::M_NUM; runlen_d = POS_WIDTH'(1);
				end else if (slbs_pkg::is_op_start(b)) begin
					mode_d = slbs_pkg::M_OP; pend_d = b;
				end else begin
					e1 = '0; e1.row = crow_q; e1.col = ccol_q; e1.len = POS_WIDTH'(1);
					e1.kind = (pk != 6'd0) ? pk : slbs_pkg::K_ERROR;
					if (pk == 6'd0) mode_d = slbs_pkg::M_ERROR;
					if (v0) v1 = 1'b1;
					else begin v0 = 1'b1; e0 = e1; end
				end
			end
			if (b == 8'h0a) begin crow_d = sinc(crow_q); ccol_d = '0; end
			else ccol_d = sinc(ccol_q);
		end
		// end of text flush uses the state after this byte
		if (last) begin
			t = '0;
			t.row = trow_d; t.col = tcol_d; t.len = runlen_d;
			case (mode_d)
				slbs_pkg::M_WORD: begin
					t.kind = slbs_pkg::K_IDENT;
					for (int i = 13; i >= 0; i--)
						if (prefix_d == slbs_pkg::PRIM_NAME[i] &&
							runlen_d == POS_WIDTH'(slbs_pkg::PRIM_LEN[i])) begin
							t.kind = slbs_pkg::K_PRIM; t.prim = 4'(i);
						end
					if (prefix_d == slbs_pkg::FUNC_NAME && runlen_d == POS_WIDTH'(4)) begin
						t.kind = slbs_pkg::K_FUNC; t.prim = 4'd0;
					end
				end
				slbs_pkg::M_NUM: begin
					t.kind = slbs_pkg::K_INT; t.suf = slbs_pkg::SUF_NONE;
				end
				slbs_pkg::M_SUFFIX: begin
					t.kind = slbs_pkg::K_INT;
					case (sdig_d)
						7'd8:  t.suf = {3'd0, sletter_d};
						7'd16: t.suf = {3'd1, sletter_d};
						7'd32: t.suf = {3'd2, sletter_d};
						7'd64: t.suf = {3'd3, sletter_d};
						default: t.bad = 1'b1;
					endcase
				end
				slbs_pkg::M_OP: begin
					t.kind = slbs_pkg::op_single(pend_d); t.len = POS_WIDTH'(1);
				end
				default: ;
			endcase
			if (mode_d == slbs_pkg::M_WORD || mode_d == slbs_pkg::M_NUM ||
				mode_d == slbs_pkg::M_SUFFIX || mode_d == slbs_pkg::M_OP) begin
				if (v0) begin v1 = 1'b1; e1 = t; end
				else begin v0 = 1'b1; e0 = t; end
			end
			if (mode_d != slbs_pkg::M_ERROR) mode_d = slbs_pkg::M_IDLE;
			crow_d = '0; ccol_d = '0;
		end
		if (v1) e1.last = 1'b1;
		else e0.last = 1'b1;
	end

	// scanner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= slbs_pkg::M_IDLE; pend_q <= '0; prefix_q <= '0; runlen_q <= '0;
			trow_q <= '0; tcol_q <= '0; crow_q <= '0; ccol_q <= '0;
			sletter_q <= 1'b0; sdig_q <= '0;
		end else if (acc) begin
			mode_q <= mode_d; pend_q <= pend_d; prefix_q <= prefix_d; runlen_q <= runlen_d;
			trow_q <= trow_d; tcol_q <= tcol_d; crow_q <= crow_d; ccol_q <= ccol_d;
			sletter_q <= sletter_d; sdig_q <= sdig_d;
		end
	end

	// token queue, head in entry 0; new tokens land behind what remains
	always_ff @(posedge clk or negedge arst_n) begin
		logic [1:0]    n;
		logic [TW-1:0] nq [3];
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			n = cnt_q - {1'b0, take};
			nq = q_q;
			if (take) begin
				nq[0] = q_q[1];
				nq[1] = q_q[2];
			end
			if (acc && v0) begin
				nq[n] = e0;
				if (v1) nq[n + 2'd1] = e1;
			end
			q_q <= nq;
			cnt_q <= n + {1'b0, acc && v0} + {1'b0, acc && v1};
		end
	end

	always_comb begin
		out_valid = (cnt_q != 2'd0);
		out_data = q_q[0];
	end
endmodule
`default_nettype wire
